>>> rtl/zhang_suen_thinning_pass_macros.svh
// Assertion macros for the thinning pass. Each macro samples on i_clk and is
// disabled while i_rst_n is low, so it can only be used inside a module that
// has both of those ports.
`ifndef ZHANG_SUEN_THINNING_PASS_MACROS_SVH
`define ZHANG_SUEN_THINNING_PASS_MACROS_SVH

`ifndef SYNTHESIS

// The condition must never be true at a clock edge.
`define ZSTP_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("zstp assertion failed: condition must never hold");

// The consequent must hold in the same cycle as the antecedent.
`define ZSTP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("zstp assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ZSTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("zstp assertion failed: next-cycle implication");

`else

`define ZSTP_ASSERT_NEVER(label, cond)
`define ZSTP_ASSERT_IMPLY(label, ante, cons)
`define ZSTP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/zst_pkg.sv
package zst_pkg;

    // Default line buffer depth in pixels.
    localparam int MAX_WIDTH_DEF = 2048;

    // Field and counter widths fixed by the register map and the stream format.
    localparam int DIM_W      = 12;
    localparam int ROW_W      = 13;
    localparam int TOTAL_W    = 23;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - TOTAL_W - 2;

    // Each line buffer entry holds the upper row bit and the middle row bit.
    localparam int LINE_BITS = 2;
    localparam int LINE_MID  = 0;
    localparam int LINE_UP   = 1;

    // Neighbor count limits for a removable pixel.
    localparam int NEIGH_MIN = 2;
    localparam int NEIGH_MAX = 6;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SUBITER = 2'd0,
        CFG_BG_ONES = 2'd1,
        CFG_WIDTH   = 2'd2,
        CFG_HEIGHT  = 2'd3
    } t_cfg_index;

    // Input word kinds.
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // Window handed to the judge stage: bit slot*3+row, slot 0 is west.
    typedef struct packed {
        logic       last;
        logic [8:0] win;
    } t_judge_req;

    // One result word.
    typedef struct packed {
        logic [TOTAL_W-1:0] removed_total;
        logic               frame_last;
        logic               removed;
        logic               out_pixel;
    } t_result;

endpackage

>>> rtl/zst_line_mem.sv
module zst_line_mem
    import zst_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [LINE_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [LINE_BITS-1:0] i_wr_data
);

    logic [LINE_BITS-1:0] r_mem [DEPTH];
    logic [LINE_BITS-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; a read of the entry being written returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/zst_judge.sv
module zst_judge
    import zst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_judge_req i_req,
    input  logic       i_subiter,
    input  logic       i_bg_ones,
    output logic       o_valid,
    output t_result    o_res
);

    logic [TOTAL_W-1:0] r_removed_cnt;
    logic [TOTAL_W-1:0] n_removed_cnt;
    logic [7:0]         w_ring;
    logic [3:0]         w_cnt;
    logic [3:0]         w_steps;
    logic               w_pass;
    logic               w_center;
    logic               w_rm;
    logic [TOTAL_W-1:0] w_total;

    // Ring order N, NE, E, SE, S, SW, W, NW.
    always_comb begin
        w_ring[0] = i_req.win[3];
        w_ring[1] = i_req.win[6];
        w_ring[2] = i_req.win[7];
        w_ring[3] = i_req.win[8];
        w_ring[4] = i_req.win[5];
        w_ring[5] = i_req.win[2];
        w_ring[6] = i_req.win[1];
        w_ring[7] = i_req.win[0];
        w_center  = i_req.win[4];
    end

    // Neighbor count and background-to-foreground steps around the ring.
    always_comb begin
        w_cnt   = '0;
        w_steps = '0;
        for (int i = 0; i < 8; i++) begin
            w_cnt = w_cnt + 4'(w_ring[i]);
            if (!w_ring[i] && w_ring[(i + 1) & 7]) begin
                w_steps = w_steps + 4'd1;
            end
        end
    end

    // Directional product test of the selected subiteration.
    always_comb begin
        if (i_subiter) begin
            w_pass = !(w_ring[0] & w_ring[2] & w_ring[6]) && !(w_ring[0] & w_ring[4] & w_ring[6]);
        end else begin
            w_pass = !(w_ring[0] & w_ring[2] & w_ring[4]) && !(w_ring[2] & w_ring[4] & w_ring[6]);
        end
    end

    // Removal decision and the saturating running count.
    always_comb begin
        w_rm = w_center && (w_cnt >= 4'(NEIGH_MIN)) && (w_cnt <= 4'(NEIGH_MAX))
            && (w_steps == 4'd1) && w_pass;
        if (w_rm && (r_removed_cnt != '1)) begin
            w_total = r_removed_cnt + 1'b1;
        end else begin
            w_total = r_removed_cnt;
        end
        n_removed_cnt = r_removed_cnt;
        if (i_valid) begin
            n_removed_cnt = i_req.last ? '0 : w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_removed_cnt <= '0;
        end else begin
            r_removed_cnt <= n_removed_cnt;
        end
    end

    assign o_valid             = i_valid;
    assign o_res.out_pixel     = (w_center & ~w_rm) ^ i_bg_ones;
    assign o_res.removed       = w_rm;
    assign o_res.frame_last    = i_req.last;
    assign o_res.removed_total = w_total;

endmodule

>>> rtl/zst_out_fifo.sv
module zst_out_fifo
    import zst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output t_result            o_data,
    output logic [FIFO_CW-1:0] o_count
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic                 w_pop;

    assign w_pop = (r_count != '0) && i_ready;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

>>> rtl/zhang_suen_thinning_pass.sv
// Channel     Direction  Handshake                Contents
// s_axis      in         tvalid/tready            tdata[0] raw_pixel; tuser[0] operation
// m_axis      out        tvalid/tready, tlast     tdata out_pixel, removed, removed_total
// cfg         in         write enable, no wait    index 0..3, 12-bit data
//
// One word is accepted per clock while tready is high. A word's result, if any,
// passes the stage 1 and stage 2 registers before it is queued; a judged pixel's
// result comes image_width+1 words after it. The line buffer is one memory with
// one read and one write port; back-to-back accesses to the same column are forwarded.
// After reset a clearing pass writes zero to every line buffer entry, with
// s_axis tready low. Output stalls back up through the result queue to tready.
`include "zhang_suen_thinning_pass_macros.svh"

module zhang_suen_thinning_pass
    import zst_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input words.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [0] raw_pixel, [7:1] zero
    input  logic [0:0]            i_s_axis_tuser,   // [0] operation
    // Result words.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [0] out_pixel, [1] removed,
                                                    // [24:2] removed_total, [31:25] zero
    output logic                  o_m_axis_tlast,   // frame_last
    // Configuration.
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [DIM_W-1:0]      i_cfg_wdata
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > DIM_W) ? WW : DIM_W;

    // Configuration registers.
    logic             r_subiter;
    logic             r_bg_ones;
    logic [DIM_W-1:0] r_image_width;
    logic [DIM_W-1:0] r_image_height;

    // Position counters.
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    // Clearing pass.
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;

    // Stage 1: memory read data returns.
    logic                 r_s1_valid;
    logic                 r_s1_final;
    logic                 r_s1_first;
    logic                 r_s1_r1;
    logic                 r_s1_r2;
    logic                 r_s1_bot;
    logic [AW-1:0]        r_s1_addr;
    logic                 r_s1_fwd;
    logic [LINE_BITS-1:0] r_fwd_data;
    logic [8:0]           r_win;

    // Stage 2: judge.
    logic       r_s2_valid;
    t_judge_req r_s2_req;

    logic [CMPW-1:0]      w_w_raw;
    logic [CMPW-1:0]      w_w_sel;
    logic [WW-1:0]        w_width;
    logic [ROW_W-1:0]     w_h;
    logic [ROW_W-1:0]     w_h1;
    logic                 w_acc;
    logic                 w_wrap;
    logic [AW-1:0]        w_c;
    logic [ROW_W-1:0]     w_r;
    logic [WW-1:0]        w_c1;
    t_op                  w_op;
    logic                 w_ignore;
    logic                 w_final;
    logic                 w_normal;
    logic                 w_bot;
    logic [LINE_BITS-1:0] w_rd_data;
    logic [LINE_BITS-1:0] w_line;
    logic                 w_s1_wr;
    logic [LINE_BITS-1:0] w_s1_wr_data;
    logic [2:0]           w_col3;
    logic [8:0]           w_win_shift;
    logic [8:0]           w_win_new;
    logic                 w_mem_wr_en;
    logic [AW-1:0]        w_mem_wr_addr;
    logic [LINE_BITS-1:0] w_mem_wr_data;
    logic                 w_push;
    t_result              w_res;
    t_result              w_out;
    logic [FIFO_CW-1:0]   w_fifo_cnt;
    logic [2:0]           w_pending;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subiter      <= 1'b0;
            r_bg_ones      <= 1'b0;
            r_image_width  <= DIM_W'(2048);
            r_image_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SUBITER: r_subiter      <= i_cfg_wdata[0];
                CFG_BG_ONES: r_bg_ones      <= i_cfg_wdata[0];
                CFG_WIDTH:   r_image_width  <= i_cfg_wdata;
                CFG_HEIGHT:  r_image_height <= i_cfg_wdata;
                default:     r_subiter      <= r_subiter;
            endcase
        end
    end

    // Effective width and height: zero acts as one, width clamps to the buffer depth.
    always_comb begin
        w_w_raw = CMPW'(r_image_width);
        if (w_w_raw == '0) begin
            w_w_sel = CMPW'(1);
        end else if (w_w_raw > CMPW'(MAX_WIDTH)) begin
            w_w_sel = CMPW'(MAX_WIDTH);
        end else begin
            w_w_sel = w_w_raw;
        end
        w_width = WW'(w_w_sel);
        w_h     = (r_image_height == '0) ? ROW_W'(1) : ROW_W'(r_image_height);
        w_h1    = w_h + 1'b1;
    end

    // Flow control: room in the queue for every word that may still yield a result.
    assign w_pending       = 3'(w_fifo_cnt) + 3'(r_s1_valid) + 3'(r_s2_valid);
    assign o_s_axis_tready = !r_clr_busy && (w_pending <= 3'(FIFO_DEPTH - 1));
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // Stage 0: position of the word and its kind.
    always_comb begin
        w_op     = t_op'(i_s_axis_tuser[0]);
        w_wrap   = (WW'(r_col) >= w_width);
        w_c      = w_wrap ? '0 : r_col;
        w_r      = w_wrap ? r_row + 1'b1 : r_row;
        w_ignore = (w_r < w_h) && (w_op == OP_DRAIN);
        w_final  = !w_ignore && (w_r >= w_h1);
        w_normal = !w_ignore && !w_final;
        w_bot    = (w_r < w_h) ? (i_s_axis_tdata[0] ^ r_bg_ones) : 1'b0;
        w_c1     = WW'(w_c) + 1'b1;
        n_col    = r_col;
        n_row    = r_row;
        if (w_acc) begin
            if (w_ignore) begin
                n_col = w_c;
                n_row = w_r;
            end else if (w_final) begin
                n_col = '0;
                n_row = '0;
            end else if (w_c1 >= w_width) begin
                n_col = '0;
                n_row = w_r + 1'b1;
            end else begin
                n_col = w_c1[AW-1:0];
                n_row = w_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Clearing pass over the line buffer after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Stage 1 line data, forwarded when the previous word wrote the same column.
    always_comb begin
        w_line       = r_s1_fwd ? r_fwd_data : w_rd_data;
        w_s1_wr      = r_s1_valid && !r_s1_final;
        w_s1_wr_data = '0;
        w_s1_wr_data[LINE_UP]  = w_line[LINE_MID];
        w_s1_wr_data[LINE_MID] = r_s1_bot;
        w_col3 = {r_s1_bot, r_s1_r1 & w_line[LINE_MID], r_s1_r2 & w_line[LINE_UP]};
        w_win_shift = r_win >> 3;
        w_win_new   = w_win_shift | {w_col3, 6'b0};
    end

    // Memory write port: clearing pass first, then the read-modify-write.
    always_comb begin
        if (r_clr_busy) begin
            w_mem_wr_en   = 1'b1;
            w_mem_wr_addr = r_clr_addr;
            w_mem_wr_data = '0;
        end else begin
            w_mem_wr_en   = w_s1_wr;
            w_mem_wr_addr = r_s1_addr;
            w_mem_wr_data = w_s1_wr_data;
        end
    end

    zst_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_acc && w_normal),
        .i_rd_addr (w_c),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data)
    );

    // Stage 0 to stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc && !w_ignore;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_final <= w_final;
        r_s1_first <= (w_c == '0);
        r_s1_r1    <= (w_r >= ROW_W'(1));
        r_s1_r2    <= (w_r >= ROW_W'(2));
        r_s1_bot   <= w_bot;
        r_s1_addr  <= w_c;
        r_s1_fwd   <= w_acc && w_normal && w_s1_wr && (r_s1_addr == w_c);
        r_fwd_data <= w_s1_wr_data;
    end

    // Window shift and choice of the pixel to judge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= 1'b0;
            if (r_s1_valid) begin
                if (r_s1_final) begin
                    r_win      <= '0;
                    r_s2_valid <= 1'b1;
                end else if (r_s1_first) begin
                    r_win      <= {w_col3, 6'b0};
                    r_s2_valid <= r_s1_r2;
                end else begin
                    r_win      <= w_win_new;
                    r_s2_valid <= r_s1_r1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_final || r_s1_first) begin
            r_s2_req.win <= w_win_shift;
        end else begin
            r_s2_req.win <= w_win_new;
        end
        r_s2_req.last <= r_s1_final;
    end

    zst_judge u_judge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s2_valid),
        .i_req     (r_s2_req),
        .i_subiter (r_subiter),
        .i_bg_ones (r_bg_ones),
        .o_valid   (w_push),
        .o_res     (w_res)
    );

    zst_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out),
        .o_count (w_fifo_cnt)
    );

    assign o_m_axis_tdata = {OUT_PAD_W'(0), w_out.removed_total, w_out.removed, w_out.out_pixel};
    assign o_m_axis_tlast = w_out.frame_last;

    // The queue always has room for what the pipeline delivers.
    `ZSTP_ASSERT_NEVER(a_fifo_no_overflow, w_push && (w_fifo_cnt == FIFO_CW'(FIFO_DEPTH)))
    // A judge request only follows a word in the read stage.
    `ZSTP_ASSERT_IMPLY(a_s2_from_s1, r_s2_valid, $past(r_s1_valid))
    // The clearing pass covers every column before input opens.
    `ZSTP_ASSERT_IMPLY(a_clear_len, $fell(r_clr_busy), $past(r_clr_addr) == AW'(MAX_WIDTH - 1))

endmodule
